// ===== hw/rtl/stack_slot_bitmap_allocator_assert.svh =====
// Assertion macros for the stack slot allocator.
// No dependencies; included by the top level.
`ifndef STACK_SLOT_BITMAP_ALLOCATOR_ASSERT_SVH
`define STACK_SLOT_BITMAP_ALLOCATOR_ASSERT_SVH

// Same-cycle implication.
`define SSBA_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SSBA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/ssba_pkg.sv =====
// Shared types, constants and helpers for the stack slot allocator.
// No dependencies.
package ssba_pkg;

  localparam int CMD_W     = 1;
  localparam int SLOT_W    = 6;
  localparam int STATUS_W  = 2;
  localparam int ADDR_W    = 48;
  localparam int SIZE_W    = 31;
  localparam int SLOTB_W   = 32;
  localparam int CNT_W     = 7;
  localparam int CHUNK_W   = 8;
  localparam int CFG_IDX_W = 2;

  localparam logic [CMD_W-1:0] CMD_ALLOC = 1'b0;
  localparam logic [CMD_W-1:0] CMD_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_SLOTS  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_STACK_REQUEST = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GUARD_BYTES   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_TOP    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_BASE   = 2'd3;

  localparam logic [SIZE_W-1:0] PAGE_BYTES = 31'h0000_1000;
  localparam logic [SIZE_W-1:0] PAGE_MASK  = 31'h0000_0FFF;
  localparam logic [SIZE_W-1:0] REQ_CAP    = 31'h4000_0000;

  localparam logic [SIZE_W-1:0] RST_STACK_REQUEST = 31'h0000_1000;
  localparam logic [SIZE_W-1:0] RST_GUARD_BYTES   = 31'h0000_1000;

  typedef struct packed {
    logic       any;
    logic [2:0] first;
    logic [3:0] ones;
  } chunk_info_t;

  // Page-aligned usable stack size; zero request means one page.
  function automatic logic [SIZE_W-1:0] usable_bytes(input logic [SIZE_W-1:0] req);
    logic [SIZE_W-1:0] r;
    r = (req == '0) ? PAGE_BYTES : req;
    if (r > REQ_CAP) begin
      r = REQ_CAP;
    end
    return (r + PAGE_MASK) & ~PAGE_MASK;
  endfunction

endpackage

// ===== hw/rtl/ssba_req_if.sv =====
// Request channel: command and slot index with valid/ready.
// Depends on ssba_pkg.
interface ssba_req_if;
  logic                         valid;
  logic                         ready;
  logic [ssba_pkg::CMD_W-1:0]   cmd;
  logic [ssba_pkg::SLOT_W-1:0]  slot_sel;

  modport source (output valid, cmd, slot_sel, input ready);
  modport sink (input valid, cmd, slot_sel, output ready);
endinterface

// ===== hw/rtl/ssba_rsp_if.sv =====
// Response channel: status, grant, addresses and usage count with valid/ready.
// Depends on ssba_pkg.
interface ssba_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [ssba_pkg::STATUS_W-1:0] status;
  logic [ssba_pkg::SLOT_W-1:0]   granted_index;
  logic [ssba_pkg::ADDR_W-1:0]   stack_base;
  logic [ssba_pkg::ADDR_W-1:0]   stack_top;
  logic [ssba_pkg::SIZE_W-1:0]   stack_bytes;
  logic [ssba_pkg::CNT_W-1:0]    used_slots;

  modport source (output valid, status, granted_index, stack_base, stack_top, stack_bytes,
                  used_slots, input ready);
  modport sink (input valid, status, granted_index, stack_base, stack_top, stack_bytes,
                used_slots, output ready);
endinterface

// ===== hw/rtl/ssba_cfg_if.sv =====
// Configuration write channel: register index and data with valid/ready.
// Depends on ssba_pkg.
interface ssba_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [ssba_pkg::CFG_IDX_W-1:0] index;
  logic [ssba_pkg::ADDR_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/ssba_alu.sv =====
// Shared 48-bit subtract/compare unit used for region size, division and
// slot address steps. Depends on ssba_pkg.
module ssba_alu (
  input  logic [ssba_pkg::ADDR_W-1:0] a,
  input  logic [ssba_pkg::ADDR_W-1:0] b,
  output logic [ssba_pkg::ADDR_W-1:0] diff,
  output logic                        borrow
);

  assign {borrow, diff} = {1'b0, a} - {1'b0, b};

endmodule

// ===== hw/rtl/ssba_chunk.sv =====
// One bitmap chunk: lowest set bit and population count.
// Depends on ssba_pkg.
module ssba_chunk (
  input  logic [ssba_pkg::CHUNK_W-1:0] bits,
  output ssba_pkg::chunk_info_t        info
);

  always_comb begin
    info.any   = 1'b0;
    info.first = '0;
    info.ones  = '0;
    for (int i = ssba_pkg::CHUNK_W - 1; i >= 0; i--) begin
      if (bits[i]) begin
        info.any   = 1'b1;
        info.first = 3'(i);
        info.ones  = info.ones + 4'd1;
      end
    end
  end

endmodule

// ===== hw/rtl/stack_slot_bitmap_allocator.sv =====
// Stack slot allocator: first-fit bitmap over slots carved down from the region top.
// Usage: cfg writes stack_request(0), guard_bytes(1), area top(2), area base(3);
// req carries cmd (0 alloc, 1 free) and slot_sel; rsp returns one response per
// request with status, granted_index, stack_base, stack_top, stack_bytes, used_slots.
// Handling is one request at a time: req.ready is high only while the sequencer idles.
// Free: the request goes straight from acceptance to the final step, which loads the response register.
// Alloc: chunk scan (1 to ceil(MAX_SLOT_COUNT/8) chunks, 8 bitmap bits per cycle)
// + 6 shift-subtract steps for index * slot size + 1 base step + 1 load step;
// the shared 48-bit subtractor sets the pace.
// Config write: 1 size step, up to 8 restoring division steps on the same subtractor,
// a clamp step and a trim step for the bitmap, then a recount over
// ceil(MAX_SLOT_COUNT/8) chunks; cfg.ready and req.ready stay low meanwhile.
// Reset (rst, synchronous): registers take 4096, 4096, 0, 0, bitmap clears, slot
// count is zero. A stalled rsp holds its response; a new request is taken while it
// waits, and its response waits in the final step until the output register frees.
// Depends on ssba_pkg, the channel interfaces, ssba_alu and ssba_chunk.
module stack_slot_bitmap_allocator #(
  parameter int MAX_SLOT_COUNT = 64
) (
  input logic       clk,
  input logic       rst,
  ssba_cfg_if.sink  cfg,
  ssba_req_if.sink  req,
  ssba_rsp_if.source rsp
);

  `include "stack_slot_bitmap_allocator_assert.svh"

  localparam int NCHUNK = (MAX_SLOT_COUNT + ssba_pkg::CHUNK_W - 1) / ssba_pkg::CHUNK_W;
  localparam int PAD_W  = NCHUNK * ssba_pkg::CHUNK_W;
  localparam int CPTR_W = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
  localparam int IDX_W  = (MAX_SLOT_COUNT > 1) ? $clog2(MAX_SLOT_COUNT) : 1;
  localparam logic [ssba_pkg::CNT_W-1:0] MAX_CNT    = ssba_pkg::CNT_W'(MAX_SLOT_COUNT);
  localparam logic [CPTR_W-1:0]          LAST_CHUNK = CPTR_W'(NCHUNK - 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PREP  = 4'd1;
  localparam logic [3:0] S_DIV   = 4'd2;
  localparam logic [3:0] S_CLAMP = 4'd3;
  localparam logic [3:0] S_TRIM  = 4'd4;
  localparam logic [3:0] S_COUNT = 4'd5;
  localparam logic [3:0] S_SCAN  = 4'd6;
  localparam logic [3:0] S_MUL   = 4'd7;
  localparam logic [3:0] S_BASE  = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  localparam int AW = ssba_pkg::ADDR_W;
  localparam int SW = ssba_pkg::SIZE_W;
  localparam int BW = ssba_pkg::SLOTB_W;

  logic [3:0]                      state;
  logic [SW-1:0]                   stack_request;
  logic [SW-1:0]                   guard_bytes;
  logic [AW-1:0]                   area_top;
  logic [AW-1:0]                   area_base;
  logic [MAX_SLOT_COUNT-1:0]       used_map;
  logic [ssba_pkg::CNT_W-1:0]      slot_limit;
  logic [ssba_pkg::CNT_W-1:0]      used_cnt;
  logic [BW-1:0]                   slot_bytes;
  logic [SW-1:0]                   stack_bytes;
  logic [AW-1:0]                   acc;
  logic [AW-1:0]                   base_r;
  logic [7:0]                      quo;
  logic [2:0]                      step;
  logic [CPTR_W-1:0]               ptr;
  logic [ssba_pkg::SLOT_W-1:0]     grant;
  logic [ssba_pkg::STATUS_W-1:0]   status_r;
  logic                            out_valid;

  logic                            cfg_fire;
  logic                            req_fire;
  logic                            out_load;
  logic [MAX_SLOT_COUNT-1:0]       lim_mask;
  logic [PAD_W-1:0]                map_pad;
  logic [PAD_W-1:0]                free_pad;
  logic [ssba_pkg::CHUNK_W-1:0]    chunk_bits;
  ssba_pkg::chunk_info_t           chunk_info;
  logic [AW-1:0]                   alu_a;
  logic [AW-1:0]                   alu_b;
  logic [AW-1:0]                   alu_diff;
  logic                            alu_borrow;
  logic [AW-1:0]                   sb_ext;
  logic [AW-1:0]                   usable_ext;

  assign cfg.ready = (state == S_IDLE);
  assign req.ready = (state == S_IDLE) && !cfg.valid;
  assign cfg_fire  = cfg.valid && cfg.ready;
  assign req_fire  = req.valid && req.ready;
  assign out_load  = (state == S_DONE) && (!out_valid || rsp.ready);

  always_comb begin
    for (int i = 0; i < MAX_SLOT_COUNT; i++) begin
      lim_mask[i] = (ssba_pkg::CNT_W'(i) < slot_limit);
    end
  end

  assign map_pad    = PAD_W'(used_map);
  assign free_pad   = PAD_W'(~used_map & lim_mask);
  assign chunk_bits = (state == S_SCAN) ? free_pad[ptr * ssba_pkg::CHUNK_W +: ssba_pkg::CHUNK_W]
                                        : map_pad[ptr * ssba_pkg::CHUNK_W +: ssba_pkg::CHUNK_W];

  ssba_chunk u_chunk (
    .bits (chunk_bits),
    .info (chunk_info)
  );

  assign sb_ext     = {{(AW - BW){1'b0}}, slot_bytes};
  assign usable_ext = {{(AW - SW){1'b0}}, stack_bytes};

  always_comb begin
    alu_a = acc;
    alu_b = '0;
    case (state)
      S_PREP: begin
        alu_a = area_top;
        alu_b = area_base;
      end
      S_DIV: begin
        alu_b = sb_ext << step;
      end
      S_MUL: begin
        alu_b = grant[step] ? (sb_ext << step) : '0;
      end
      S_BASE: begin
        alu_b = usable_ext;
      end
      default: begin
        alu_b = '0;
      end
    endcase
  end

  ssba_alu u_alu (
    .a      (alu_a),
    .b      (alu_b),
    .diff   (alu_diff),
    .borrow (alu_borrow)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      stack_request <= ssba_pkg::RST_STACK_REQUEST;
      guard_bytes   <= ssba_pkg::RST_GUARD_BYTES;
      area_top      <= '0;
      area_base     <= '0;
      used_map      <= '0;
      slot_limit    <= '0;
      used_cnt      <= '0;
      stack_bytes   <= ssba_pkg::usable_bytes(ssba_pkg::RST_STACK_REQUEST);
      ptr           <= '0;
      step          <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cfg_fire) begin
            case (cfg.index)
              ssba_pkg::REG_STACK_REQUEST: stack_request <= cfg.data[SW-1:0];
              ssba_pkg::REG_GUARD_BYTES:   guard_bytes   <= cfg.data[SW-1:0];
              ssba_pkg::REG_REGION_TOP:    area_top      <= cfg.data;
              ssba_pkg::REG_REGION_BASE:   area_base     <= cfg.data;
              default:                     area_base     <= area_base;
            endcase
            state <= S_PREP;
          end else if (req_fire) begin
            grant  <= '0;
            acc    <= '0;
            base_r <= '0;
            ptr    <= '0;
            if (req.cmd == ssba_pkg::CMD_FREE) begin
              state <= S_DONE;
              if ({1'b0, req.slot_sel} >= slot_limit) begin
                status_r <= ssba_pkg::ST_BAD_INDEX;
              end else begin
                status_r <= ssba_pkg::ST_OK;
                if (used_map[req.slot_sel[IDX_W-1:0]]) begin
                  used_map <= used_map & ~(MAX_SLOT_COUNT'(1) << req.slot_sel[IDX_W-1:0]);
                  used_cnt <= used_cnt - ssba_pkg::CNT_W'(1);
                end
              end
            end else if (slot_limit == '0) begin
              status_r <= ssba_pkg::ST_NO_SLOTS;
              state    <= S_DONE;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_PREP: begin
          acc         <= alu_borrow ? '0 : alu_diff;
          slot_bytes  <= {1'b0, ssba_pkg::usable_bytes(stack_request)} + {1'b0, guard_bytes};
          stack_bytes <= ssba_pkg::usable_bytes(stack_request);
          quo         <= '0;
          step        <= 3'd7;
          state       <= S_DIV;
        end
        S_DIV: begin
          if (!alu_borrow) begin
            acc       <= alu_diff;
            quo[step] <= 1'b1;
          end
          // quotient of 128 or more saturates, remaining steps would be invalid
          if (step == 3'd0 || (step == 3'd7 && !alu_borrow)) begin
            state <= S_CLAMP;
          end else begin
            step <= step - 3'd1;
          end
        end
        S_CLAMP: begin
          slot_limit <= (quo >= {1'b0, MAX_CNT}) ? MAX_CNT : quo[ssba_pkg::CNT_W-1:0];
          state      <= S_TRIM;
        end
        S_TRIM: begin
          used_map <= used_map & lim_mask;
          used_cnt <= '0;
          ptr      <= '0;
          state    <= S_COUNT;
        end
        S_COUNT: begin
          used_cnt <= used_cnt + ssba_pkg::CNT_W'(chunk_info.ones);
          if (ptr == LAST_CHUNK) begin
            state <= S_IDLE;
          end else begin
            ptr <= ptr + CPTR_W'(1);
          end
        end
        S_SCAN: begin
          if (chunk_info.any) begin
            grant    <= ssba_pkg::SLOT_W'({ptr, chunk_info.first});
            used_map <= used_map | (MAX_SLOT_COUNT'(1) << {ptr, chunk_info.first});
            used_cnt <= used_cnt + ssba_pkg::CNT_W'(1);
            status_r <= ssba_pkg::ST_OK;
            acc      <= area_top;
            step     <= 3'd5;
            state    <= S_MUL;
          end else if (ptr == LAST_CHUNK) begin
            status_r <= ssba_pkg::ST_FULL;
            state    <= S_DONE;
          end else begin
            ptr <= ptr + CPTR_W'(1);
          end
        end
        S_MUL: begin
          acc <= alu_diff;
          if (step == 3'd0) begin
            state <= S_BASE;
          end else begin
            step <= step - 3'd1;
          end
        end
        S_BASE: begin
          base_r <= alu_diff;
          state  <= S_DONE;
        end
        S_DONE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rsp.status        <= status_r;
      rsp.granted_index <= grant;
      rsp.stack_top     <= acc;
      rsp.stack_base    <= base_r;
      rsp.stack_bytes   <= stack_bytes;
      rsp.used_slots    <= used_cnt;
    end
  end

  assign rsp.valid = out_valid;

  `SSBA_ASSERT_NOW(a_cnt_match, clk, rst, state == S_IDLE, $countones(used_map) == int'(used_cnt), "used count out of step with bitmap")
  `SSBA_ASSERT_NOW(a_map_in_limit, clk, rst, state == S_IDLE, (used_map & ~lim_mask) == '0, "bitmap bit set at or above slot limit")
  `SSBA_ASSERT_NOW(a_grant_in_limit, clk, rst, state == S_DONE && status_r == ssba_pkg::ST_OK && grant != '0, ({1'b0, grant} < slot_limit), "grant outside slot limit")
  `SSBA_ASSERT_NEXT(a_free_done, clk, rst, req_fire && req.cmd == ssba_pkg::CMD_FREE, state == S_DONE, "free request did not finish in one step")

endmodule

// ===== bench/ssba_alloc_checker.sv =====
// Watches the config, request and response channels of the stack slot allocator,
// predicts every response from its own model of the slot bitmap and compares.
// Depends on ssba_pkg and the three channel interfaces.
`timescale 1ns / 1ps

module ssba_alloc_checker #(
  parameter int SLOT_CAP = 64
) (
  input  logic       clk,
  input  logic       rst,
  ssba_cfg_if        cfg,
  ssba_req_if        req,
  ssba_rsp_if        rsp,
  output int         mismatches,
  output int         outstanding,
  output int         checked,
  output logic [3:0] statuses_seen
);

  typedef struct packed {
    logic [ssba_pkg::STATUS_W-1:0] status;
    logic [ssba_pkg::SLOT_W-1:0]   granted;
    logic [ssba_pkg::ADDR_W-1:0]   base;
    logic [ssba_pkg::ADDR_W-1:0]   top;
    logic [ssba_pkg::SIZE_W-1:0]   bytes;
    logic [ssba_pkg::CNT_W-1:0]    used;
  } slot_reply_t;

  slot_reply_t owed_replies[$];

  logic [ssba_pkg::SIZE_W-1:0] want_bytes;
  logic [ssba_pkg::SIZE_W-1:0] gap_bytes;
  logic [ssba_pkg::ADDR_W-1:0] top_addr;
  logic [ssba_pkg::ADDR_W-1:0] base_addr;
  logic [63:0]                 taken;
  logic [6:0]                  slot_cnt;

  function automatic logic [ssba_pkg::SIZE_W-1:0] rounded_stack(
      input logic [ssba_pkg::SIZE_W-1:0] asked);
    logic [31:0] r;
    r = (asked == '0) ? 32'(ssba_pkg::PAGE_BYTES) : 32'(asked);
    if (r > 32'(ssba_pkg::REQ_CAP)) begin
      r = 32'(ssba_pkg::REQ_CAP);
    end
    r = (r + 32'(ssba_pkg::PAGE_MASK)) & ~32'(ssba_pkg::PAGE_MASK);
    return r[ssba_pkg::SIZE_W-1:0];
  endfunction

  function automatic logic [63:0] span_bytes();
    return 64'(rounded_stack(want_bytes)) + 64'(gap_bytes);
  endfunction

  // Slot count follows every register write; bits past the new count drop.
  function automatic void refit_slots();
    logic [63:0] room;
    logic [63:0] n;
    room = (base_addr > top_addr) ? 64'd0 : 64'(top_addr - base_addr);
    n = room / span_bytes();
    if (n > 64'(SLOT_CAP)) begin
      n = 64'(SLOT_CAP);
    end
    slot_cnt = n[6:0];
    if (n < 64) begin
      taken &= (64'd1 << n) - 64'd1;
    end
  endfunction

  function automatic slot_reply_t serve_request(input logic [ssba_pkg::CMD_W-1:0] op,
                                                input logic [ssba_pkg::SLOT_W-1:0] idx);
    slot_reply_t r;
    logic [63:0] t;
    logic        found;
    r = '0;
    found = 1'b0;
    r.bytes = rounded_stack(want_bytes);
    if (op == ssba_pkg::CMD_ALLOC) begin
      if (slot_cnt == 0) begin
        r.status = ssba_pkg::ST_NO_SLOTS;
      end else begin
        r.status = ssba_pkg::ST_FULL;
        for (int i = 0; i < 64; i++) begin
          if (!found && i < int'(slot_cnt) && !taken[i]) begin
            found = 1'b1;
            taken[i] = 1'b1;
            t = 64'(top_addr) - 64'(i) * span_bytes();
            r.status = ssba_pkg::ST_OK;
            r.granted = ssba_pkg::SLOT_W'(i);
            r.top = t[ssba_pkg::ADDR_W-1:0];
            r.base = r.top - ssba_pkg::ADDR_W'(r.bytes);
          end
        end
      end
    end else if ({1'b0, idx} >= slot_cnt) begin
      r.status = ssba_pkg::ST_BAD_INDEX;
    end else begin
      taken[idx] = 1'b0;
    end
    r.used = ssba_pkg::CNT_W'($countones(taken));
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    mismatches++;
    if (mismatches <= 40) begin
      $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    end
  endtask

  always @(posedge clk) begin
    slot_reply_t owed;
    if (rst) begin
      want_bytes = ssba_pkg::RST_STACK_REQUEST;
      gap_bytes = ssba_pkg::RST_GUARD_BYTES;
      top_addr = '0;
      base_addr = '0;
      taken = '0;
      refit_slots();
      owed_replies.delete();
      mismatches = 0;
      checked = 0;
      statuses_seen = '0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          ssba_pkg::REG_STACK_REQUEST: want_bytes = cfg.data[ssba_pkg::SIZE_W-1:0];
          ssba_pkg::REG_GUARD_BYTES:   gap_bytes = cfg.data[ssba_pkg::SIZE_W-1:0];
          ssba_pkg::REG_REGION_TOP:    top_addr = cfg.data;
          ssba_pkg::REG_REGION_BASE:   base_addr = cfg.data;
          default: ;
        endcase
        refit_slots();
      end
      if (rsp.valid && rsp.ready) begin
        if (owed_replies.size() == 0) begin
          flag_mismatch("response with no request", 64'(rsp.status), 64'd0);
        end else begin
          owed = owed_replies.pop_front();
          checked++;
          statuses_seen[rsp.status] = 1'b1;
          if (rsp.status != owed.status)
            flag_mismatch("status", 64'(rsp.status), 64'(owed.status));
          if (rsp.granted_index != owed.granted)
            flag_mismatch("granted_index", 64'(rsp.granted_index), 64'(owed.granted));
          if (rsp.stack_base != owed.base)
            flag_mismatch("stack_base", 64'(rsp.stack_base), 64'(owed.base));
          if (rsp.stack_top != owed.top)
            flag_mismatch("stack_top", 64'(rsp.stack_top), 64'(owed.top));
          if (rsp.stack_bytes != owed.bytes)
            flag_mismatch("stack_bytes", 64'(rsp.stack_bytes), 64'(owed.bytes));
          if (rsp.used_slots != owed.used)
            flag_mismatch("used_slots", 64'(rsp.used_slots), 64'(owed.used));
        end
      end
      if (req.valid && req.ready) begin
        owed_replies.push_back(serve_request(req.cmd, req.slot_sel));
      end
    end
    outstanding <= owed_replies.size();
  end

endmodule

// ===== bench/stack_slot_bitmap_allocator_tb.sv =====
// Top of the stack slot allocator bench: clock, reset, request and register stimulus,
// response back-pressure and the verdict. Depends on ssba_pkg, the channel
// interfaces, ssba_alloc_checker and the allocator itself.
`timescale 1ns / 1ps

module stack_slot_bitmap_allocator_tb;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 400;
  localparam int ITEM_GOAL   = 430;
  localparam int QUIET_AFTER = 360;

  logic clk = 1'b0;
  logic rst;

  ssba_cfg_if cfg_ch();
  ssba_req_if req_ch();
  ssba_rsp_if rsp_ch();

  int         chk_errors;
  int         chk_open;
  int         chk_checked;
  logic [3:0] chk_codes;

  int cycle_count = 0;
  int sent = 0;
  int writes = 0;
  bit quiet = 1'b0;
  bit hold_drain = 1'b0;

  stack_slot_bitmap_allocator #(.MAX_SLOT_COUNT(64)) i_dut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_ch),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  ssba_alloc_checker #(.SLOT_CAP(64)) i_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg_ch),
    .req           (req_ch),
    .rsp           (rsp_ch),
    .mismatches    (chk_errors),
    .outstanding   (chk_open),
    .checked       (chk_checked),
    .statuses_seen (chk_codes)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Response side: random stalls, one long hold on request, always ready at the tail.
  initial begin
    rsp_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_drain) begin
        rsp_ch.ready <= 1'b0;
        for (int c = 0; c < HOLD_CYCLES; c++) @(posedge clk);
        hold_drain = 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        rsp_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] slot_span(input logic [ssba_pkg::SIZE_W-1:0] asked,
                                            input logic [ssba_pkg::SIZE_W-1:0] gap);
    logic [63:0] r;
    r = (asked == '0) ? 64'(ssba_pkg::PAGE_BYTES) : 64'(asked);
    if (r > 64'(ssba_pkg::REQ_CAP)) r = 64'(ssba_pkg::REQ_CAP);
    return ((r + 64'(ssba_pkg::PAGE_MASK)) & ~64'(ssba_pkg::PAGE_MASK)) + 64'(gap);
  endfunction

  task automatic push_request(input logic [ssba_pkg::CMD_W-1:0] op,
                              input logic [ssba_pkg::SLOT_W-1:0] idx);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.cmd <= op;
    req_ch.slot_sel <= idx;
    do @(posedge clk); while (!req_ch.ready);
    sent++;
  endtask

  task automatic alloc_req();
    push_request(ssba_pkg::CMD_ALLOC, ssba_pkg::SLOT_W'($urandom));
  endtask

  task automatic write_reg(input logic [ssba_pkg::CFG_IDX_W-1:0] which,
                           input logic [ssba_pkg::ADDR_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= which;
    cfg_ch.data <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
    writes++;
  endtask

  // Stop offering requests and wait until every response has been taken.
  task automatic settle();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (chk_open != 0);
  endtask

  task automatic program_layout(input logic [ssba_pkg::SIZE_W-1:0] asked,
                                input logic [ssba_pkg::SIZE_W-1:0] gap,
                                input logic [ssba_pkg::ADDR_W-1:0] top,
                                input logic [ssba_pkg::ADDR_W-1:0] base);
    write_reg(ssba_pkg::REG_STACK_REQUEST, {17'($urandom_range(0, 1) * $urandom), asked});
    write_reg(ssba_pkg::REG_GUARD_BYTES, {17'($urandom_range(0, 1) * $urandom), gap});
    write_reg(ssba_pkg::REG_REGION_TOP, top);
    write_reg(ssba_pkg::REG_REGION_BASE, base);
  endtask

  task automatic random_layout(output int slots);
    logic [ssba_pkg::SIZE_W-1:0] asked;
    logic [ssba_pkg::SIZE_W-1:0] gap;
    logic [63:0]                 span;
    logic [63:0]                 need;
    logic [63:0]                 top;
    logic [63:0]                 base;
    case ($urandom_range(0, 4))
      0: asked = '0;
      1: asked = ssba_pkg::SIZE_W'($urandom_range(1, 20000));
      2: asked = ssba_pkg::SIZE_W'($urandom_range(1, 256)) << 12;
      3: asked = ssba_pkg::REQ_CAP | ssba_pkg::SIZE_W'($urandom_range(0, 1) * $urandom);
      default: asked = ssba_pkg::SIZE_W'($urandom);
    endcase
    case ($urandom_range(0, 3))
      0: gap = '0;
      1: gap = ssba_pkg::SIZE_W'($urandom_range(0, 64)) << 12;
      2: gap = ssba_pkg::SIZE_W'($urandom);
      default: gap = '1;
    endcase
    span = slot_span(asked, gap);
    case ($urandom_range(0, 9))
      0: begin
        top = rand64() >> 17;
        base = top + 64'd1 + (rand64() >> 18);
        slots = 0;
      end
      1: begin
        top = 64'h0000_FFFF_FFFF_FFFF - (rand64() >> 36);
        base = rand64() >> 40;
        slots = 64;
      end
      default: begin
        slots = ($urandom_range(0, 2) != 0) ? $urandom_range(1, 8) : $urandom_range(9, 64);
        need = 64'(slots) * span + rand64() % span;
        top = need + rand64() % (64'h0001_0000_0000_0000 - need);
        base = top - need;
      end
    endcase
    program_layout(asked, gap, top[ssba_pkg::ADDR_W-1:0], base[ssba_pkg::ADDR_W-1:0]);
  endtask

  task automatic mixed_traffic(input int slots, input int count);
    int pick;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        alloc_req();
      end else if (pick < 93 && slots > 0) begin
        push_request(ssba_pkg::CMD_FREE, ssba_pkg::SLOT_W'($urandom_range(0, slots - 1)));
      end else begin
        push_request(ssba_pkg::CMD_FREE, ssba_pkg::SLOT_W'($urandom));
      end
    end
  endtask

  task automatic fill_drain(input int slots);
    int start;
    start = $urandom_range(0, 63);
    for (int k = 0; k < slots + 2; k++) alloc_req();
    for (int k = 0; k < slots; k++)
      push_request(ssba_pkg::CMD_FREE, ssba_pkg::SLOT_W'((start + k) % slots));
  endtask

  initial begin
    logic [ssba_pkg::ADDR_W-1:0] top_a;
    logic [ssba_pkg::ADDR_W-1:0] top_c;
    int                          slots;
    bit                          first;
    rst <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.cmd <= ssba_pkg::CMD_ALLOC;
    req_ch.slot_sel <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= ssba_pkg::REG_STACK_REQUEST;
    cfg_ch.data <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Out of reset the region is empty.
    alloc_req();
    push_request(ssba_pkg::CMD_FREE, 6'd0);
    push_request(ssba_pkg::CMD_FREE, 6'd63);

    // Zero request, no guard, three one-page slots.
    settle();
    top_a = 48'h0000_0100_0000;
    program_layout('0, '0, top_a, top_a - 48'(3 * 4096 + 4095));
    repeat (4) alloc_req();
    push_request(ssba_pkg::CMD_FREE, 6'd3);
    push_request(ssba_pkg::CMD_FREE, 6'd1);
    push_request(ssba_pkg::CMD_FREE, 6'd1);
    alloc_req();

    // Shrink to one slot: the upper bits drop out of the map.
    settle();
    write_reg(ssba_pkg::REG_REGION_BASE, top_a - 48'd4196);
    alloc_req();
    push_request(ssba_pkg::CMD_FREE, 6'd1);
    push_request(ssba_pkg::CMD_FREE, 6'd0);

    // Base above top.
    settle();
    write_reg(ssba_pkg::REG_REGION_BASE, top_a + 48'd4096);
    alloc_req();
    push_request(ssba_pkg::CMD_FREE, 6'd0);

    // All-ones registers: capped request, widest guard, full address range.
    settle();
    write_reg(ssba_pkg::REG_STACK_REQUEST, '1);
    write_reg(ssba_pkg::REG_GUARD_BYTES, '1);
    write_reg(ssba_pkg::REG_REGION_TOP, '1);
    write_reg(ssba_pkg::REG_REGION_BASE, '0);
    repeat (3) alloc_req();
    push_request(ssba_pkg::CMD_FREE, 6'd63);
    push_request(ssba_pkg::CMD_FREE, 6'd0);

    // Request just over the cap, two slots.
    settle();
    top_c = 48'h0000_8000_1000;
    program_layout(ssba_pkg::REQ_CAP + 31'd1, '0, top_c, top_c - 48'h0000_8000_0000);
    repeat (3) alloc_req();

    first = 1'b1;
    while (sent < ITEM_GOAL) begin
      settle();
      random_layout(slots);
      if (sent > QUIET_AFTER) quiet = 1'b1;
      if (first) begin
        hold_drain = 1'b1;
        first = 1'b0;
        mixed_traffic(slots, 40);
      end else if ($urandom_range(0, 2) == 0) begin
        fill_drain(slots);
      end else begin
        mixed_traffic(slots, $urandom_range(15, 45));
      end
    end

    settle();
    repeat (20) @(posedge clk);
    $display("Run covered %0d alloc/free requests under %0d register writes, %0d responses",
             sent, writes, chk_checked);
    $display("Status codes returned (bit per code, ok is bit 0): %b", chk_codes);
    if (chk_errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
